// ===== rtl/gsct_pkg.sv =====
// Shared widths and limits of the grid segment cell traversal block.
package gsct_pkg;

  localparam int unsigned MAX_CELLS = 64;

  localparam int unsigned COORD_W = 18;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned CELL_W  = COORD_W - FRAC_W;
  localparam int unsigned SPAN_W  = COORD_W;
  localparam int unsigned FRACP_W = FRAC_W + 1;
  localparam int unsigned PROD_W  = FRACP_W + SPAN_W;
  localparam int unsigned ERR_W   = PROD_W + 2;
  localparam int unsigned TOTAL_W = CELL_W + 2;
  localparam int unsigned CNT_W   = $clog2(MAX_CELLS + 1);

  localparam int unsigned S_TDATA_W = ((4 * COORD_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((2 * CELL_W + 7) / 8) * 8;

  // Magnitude bound of the error term: one span times one whole cell.
  localparam logic signed [ERR_W-1:0] ERR_LIM = ERR_W'(1) <<< (SPAN_W + FRAC_W);

endpackage

// ===== rtl/grid_segment_cell_traversal.sv =====
// Top level of the grid segment cell traversal block.
//
// The slave stream takes one segment per transaction: start and end points in
// cell units, signed fixed point with eight fraction bits. The master stream
// returns one transaction per grid cell that the segment crosses, in order
// from the start cell, with tlast on the final cell of the segment and tuser
// set on every cell of a segment whose run was cut at MAX_CELLS cells.
// A segment is taken only while the sequencer is idle. Set-up then runs
// through S_PREP, S_MULX, S_MULY and S_SEED: span and cell count, then two
// passes through the one shared multiplier and a final pass through the
// shared add/subtract unit, which seed the error term. After that one cell
// is produced per cycle while the output register is free to take it, each
// step again using the shared adder. The output register lets a new
// segment be accepted while the final cell of the previous one still waits
// to be taken.
// When the receiver holds tready low, the stepping simply pauses with the
// current cell held in the output register; nothing is lost or repeated.
// Reset returns the sequencer to idle and empties the output register; no
// state is carried from one segment to the next.
module grid_segment_cell_traversal (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // start_x [17:0], start_y [35:18], end_x [53:36], end_y [71:54]
  input  logic [gsct_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // cell_x [9:0], cell_y [19:10], zero fill above
  output logic [gsct_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tlast,
  // truncated [0]
  output logic                             m_axis_tuser
);
  import gsct_pkg::*;

  // Sequencer codes.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_MULX = 3'd2;
  localparam logic [2:0] S_MULY = 3'd3;
  localparam logic [2:0] S_SEED = 3'd4;
  localparam logic [2:0] S_RUN  = 3'd5;

  logic [2:0] state_q, state_d;

  // Captured segment.
  logic signed [COORD_W-1:0] x0_q, y0_q, x1_q, y1_q;

  // Set-up results.
  logic [SPAN_W-1:0]  dx_q, dy_q;
  logic               xpos_q, ypos_q;
  logic [FRACP_W-1:0] fxp_q, fyp_q;
  logic [CELL_W-1:0]  cx_q, cy_q;
  logic [CNT_W-1:0]   rem_q;
  logic               trunc_q;

  // Shared multiplier and add/subtract unit.
  logic [FRACP_W-1:0]        mul_a;
  logic [SPAN_W-1:0]         mul_b;
  logic [PROD_W-1:0]         mul_p;
  logic [PROD_W-1:0]         prod_q;
  logic [ERR_W-1:0]          add_op;
  logic                      add_sub;
  logic signed [ERR_W-1:0]   err_q, err_d;

  // Output register.
  logic              m_tvalid_q;
  logic [CELL_W-1:0] ocx_q, ocy_q;
  logic              olast_q, otrunc_q;

  // Set-up arithmetic, evaluated in the preparation cycle.
  logic                       xgt, ygt;
  logic [COORD_W:0]           dx_fwd, dx_rev, dy_fwd, dy_rev;
  logic [CELL_W-1:0]          c0x, c1x, c0y, c1y;
  logic [CELL_W:0]            spanx, spany;
  logic [TOTAL_W-1:0]         total;
  logic                       trunc_c;
  logic [FRAC_W-1:0]          frx, fry;

  logic dx_zero, dy_zero, step_y, out_free, load;

  assign xgt    = x1_q > x0_q;
  assign ygt    = y1_q > y0_q;
  assign dx_fwd = {x1_q[COORD_W-1], x1_q} - {x0_q[COORD_W-1], x0_q};
  assign dx_rev = {x0_q[COORD_W-1], x0_q} - {x1_q[COORD_W-1], x1_q};
  assign dy_fwd = {y1_q[COORD_W-1], y1_q} - {y0_q[COORD_W-1], y0_q};
  assign dy_rev = {y0_q[COORD_W-1], y0_q} - {y1_q[COORD_W-1], y1_q};

  // The integer part of a coordinate is its floor, i.e. the upper bits.
  assign c0x = x0_q[COORD_W-1:FRAC_W];
  assign c1x = x1_q[COORD_W-1:FRAC_W];
  assign c0y = y0_q[COORD_W-1:FRAC_W];
  assign c1y = y1_q[COORD_W-1:FRAC_W];
  assign frx = x0_q[FRAC_W-1:0];
  assign fry = y0_q[FRAC_W-1:0];

  assign spanx = xgt ? ({c1x[CELL_W-1], c1x} - {c0x[CELL_W-1], c0x})
                     : ({c0x[CELL_W-1], c0x} - {c1x[CELL_W-1], c1x});
  assign spany = ygt ? ({c1y[CELL_W-1], c1y} - {c0y[CELL_W-1], c0y})
                     : ({c0y[CELL_W-1], c0y} - {c1y[CELL_W-1], c1y});
  assign total   = TOTAL_W'(1) + {1'b0, spanx} + {1'b0, spany};
  assign trunc_c = total > TOTAL_W'(MAX_CELLS);

  // The multiplier serves both halves of the error seed.
  always_comb begin
    if (state_q == S_MULX) begin
      mul_a = fxp_q;
      mul_b = dy_q;
    end else begin
      mul_a = fyp_q;
      mul_b = dx_q;
    end
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign dx_zero = dx_q == '0;
  assign dy_zero = dy_q == '0;

  // A vertical segment steps only in y, a horizontal one only in x; otherwise
  // a positive error term asks for a y step and a tie goes to x.
  always_comb begin
    if (dx_zero && !dy_zero) begin
      step_y = 1'b1;
    end else if (dy_zero) begin
      step_y = 1'b0;
    end else begin
      step_y = err_q > 0;
    end
  end

  assign out_free = !m_tvalid_q || m_axis_tready;
  assign load     = (state_q == S_RUN) && out_free;

  // The add/subtract unit.
  always_comb begin
    add_op  = '0;
    add_sub = 1'b0;
    unique case (state_q)
      S_MULY: begin
        add_op = ERR_W'(prod_q);
      end
      S_SEED: begin
        add_op  = ERR_W'(prod_q);
        add_sub = 1'b1;
      end
      S_RUN: begin
        if (load && !dx_zero && !dy_zero) begin
          if (step_y) begin
            add_op  = ERR_W'({dx_q, {FRAC_W{1'b0}}});
            add_sub = 1'b1;
          end else begin
            add_op = ERR_W'({dy_q, {FRAC_W{1'b0}}});
          end
        end
      end
      default: begin
        add_op = '0;
      end
    endcase
    err_d = add_sub ? err_q - $signed(add_op) : err_q + $signed(add_op);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (s_axis_tvalid) state_d = S_PREP;
      S_PREP: state_d = S_MULX;
      S_MULX: state_d = S_MULY;
      S_MULY: state_d = S_SEED;
      S_SEED: state_d = S_RUN;
      S_RUN:  if (load && rem_q == CNT_W'(1)) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign s_axis_tready = state_q == S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      m_tvalid_q <= 1'b0;
      rem_q      <= '0;
      err_q      <= '0;
    end else begin
      state_q <= state_d;
      if (load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
      if (state_q == S_PREP) begin
        rem_q <= trunc_c ? CNT_W'(MAX_CELLS) : total[CNT_W-1:0];
        err_q <= '0;
      end else begin
        if (load) begin
          rem_q <= rem_q - CNT_W'(1);
        end
        err_q <= err_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      x0_q <= s_axis_tdata[COORD_W-1:0];
      y0_q <= s_axis_tdata[2*COORD_W-1:COORD_W];
      x1_q <= s_axis_tdata[3*COORD_W-1:2*COORD_W];
      y1_q <= s_axis_tdata[4*COORD_W-1:3*COORD_W];
    end
    if (state_q == S_PREP) begin
      dx_q    <= xgt ? dx_fwd[SPAN_W-1:0] : dx_rev[SPAN_W-1:0];
      dy_q    <= ygt ? dy_fwd[SPAN_W-1:0] : dy_rev[SPAN_W-1:0];
      xpos_q  <= xgt;
      ypos_q  <= ygt;
      fxp_q   <= xgt ? FRACP_W'(1 << FRAC_W) - {1'b0, frx} : {1'b0, frx};
      fyp_q   <= ygt ? FRACP_W'(1 << FRAC_W) - {1'b0, fry} : {1'b0, fry};
      cx_q    <= c0x;
      cy_q    <= c0y;
      trunc_q <= trunc_c;
    end
    if (state_q == S_MULX || state_q == S_MULY) begin
      prod_q <= mul_p;
    end
    if (load) begin
      ocx_q    <= cx_q;
      ocy_q    <= cy_q;
      olast_q  <= rem_q == CNT_W'(1);
      otrunc_q <= trunc_q;
      if (step_y) begin
        cy_q <= ypos_q ? cy_q + CELL_W'(1) : cy_q - CELL_W'(1);
      end else begin
        cx_q <= xpos_q ? cx_q + CELL_W'(1) : cx_q - CELL_W'(1);
      end
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = M_TDATA_W'({ocy_q, ocx_q});
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = otrunc_q;

  // The run never stands on an empty cell count.
  a_run_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RUN |-> rem_q != '0)
    else $error("cell stepping with no cells left");

  // The error term stays within one span of a whole cell while stepping.
  a_err_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RUN |-> (err_q <= ERR_LIM && err_q >= -ERR_LIM))
    else $error("error term out of range");

  // Loading the final cell ends the run and frees the input side.
  a_last_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && rem_q == CNT_W'(1)) |=> (state_q == S_IDLE && m_axis_tlast))
    else $error("final cell did not end the run");

  // A vertical segment never moves in x.
  a_vertical : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && dx_zero && !dy_zero) |=> $stable(cx_q))
    else $error("x moved on a vertical segment");

endmodule

// ===== tb/grid_segment_cell_traversal_tb.sv =====
// Self-checking testbench for the grid segment cell traversal block.
`timescale 1ns / 100ps

module grid_segment_cell_traversal_tb;
  import gsct_pkg::*;

  // One segment as it travels on the slave stream, start_x in the lowest bits.
  typedef struct packed {
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_x;
  } segment_t;

  // One visited cell as it is expected on the master stream.
  typedef struct {
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic              last;
    logic              truncated;
  } cell_t;

  localparam int NUM_RANDOM = 208;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_CYC  = 80;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 m_axis_tuser;

  segment_t seg_pending_q[$];
  cell_t    cell_due_q[$];
  int       num_directed;
  int       segs_sent   = 0;
  int       segs_taken  = 0;
  int       fail_count  = 0;
  int       hold_cnt    = 0;
  bit       hold_done   = 1'b0;

  grid_segment_cell_traversal u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Idling phases follow the number of segments offered: none at first, then the
  // sender idling, then the receiver stalling, then both at a light rate.
  wire sender_idles  = (segs_sent >= num_directed + 55) && (segs_sent < num_directed + 115);
  wire recv_stalls   = (segs_sent >= num_directed + 115) && (segs_sent < num_directed + 175);
  wire both_idle     = (segs_sent >= num_directed + 175);

  // Appends one segment to the list still to be offered.
  function automatic void queue_seg(segment_t seg);
    seg_pending_q = {seg_pending_q, seg};
  endfunction

  // Works out the cells a segment visits, in order and at most MAX_CELLS of them, and queues them.
  function automatic void trace_cells(segment_t seg);
    int     x0, y0, x1, y1, cx, cy, xinc, yinc, total, count;
    longint dx, dy, err;
    bit     cut;
    cell_t  nc;
    x0 = seg.start_x;
    y0 = seg.start_y;
    x1 = seg.end_x;
    y1 = seg.end_y;
    dx = (x1 > x0) ? longint'(x1) - x0 : longint'(x0) - x1;
    dy = (y1 > y0) ? longint'(y1) - y0 : longint'(y0) - y1;
    cx = x0 >>> FRAC_W;
    cy = y0 >>> FRAC_W;
    xinc = 0;
    yinc = 0;
    total = 1;
    err = 0;
    // The error term starts from the distance to the first cell boundary in the
    // direction of travel, weighted by the span of the other axis.
    if (dx != 0) begin
      if (x1 > x0) begin
        xinc = 1;
        total += (x1 >>> FRAC_W) - cx;
        err += longint'(256 - (x0 & 255)) * dy;
      end else begin
        xinc = -1;
        total += cx - (x1 >>> FRAC_W);
        err += longint'(x0 & 255) * dy;
      end
    end
    if (dy != 0) begin
      if (y1 > y0) begin
        yinc = 1;
        total += (y1 >>> FRAC_W) - cy;
        err -= longint'(256 - (y0 & 255)) * dx;
      end else begin
        yinc = -1;
        total += cy - (y1 >>> FRAC_W);
        err -= longint'(y0 & 255) * dx;
      end
    end
    cut = (total > MAX_CELLS);
    count = cut ? MAX_CELLS : total;
    for (int k = 0; k < count; k++) begin
      nc = '{cell_x: cx[CELL_W-1:0], cell_y: cy[CELL_W-1:0],
             last: (k == count - 1), truncated: cut};
      cell_due_q = {cell_due_q, nc};
      // A zero span on one axis means only the other axis ever steps; a tie goes to x.
      if (dx == 0 && dy != 0) begin
        cy += yinc;
      end else if (dy == 0) begin
        cx += xinc;
      end else if (err > 0) begin
        cy += yinc;
        err -= 256 * dx;
      end else begin
        cx += xinc;
        err += 256 * dy;
      end
    end
  endfunction

  function automatic segment_t make_seg(int sx, int sy, int ex, int ey);
    segment_t seg;
    seg.start_x = sx[COORD_W-1:0];
    seg.start_y = sy[COORD_W-1:0];
    seg.end_x   = ex[COORD_W-1:0];
    seg.end_y   = ey[COORD_W-1:0];
    return seg;
  endfunction

  // Mostly short segments of random shape, with some axis-aligned, diagonal and
  // grid-aligned ones, and a tenth with every bit random.
  function automatic segment_t random_seg();
    int kind, reach, sx, sy, ox, oy;
    kind  = $urandom_range(0, 9);
    reach = ($urandom_range(0, 3) == 0) ? 3 * 256 : 30 * 256;
    sx = int'($urandom_range(0, 240000)) - 120000;
    sy = int'($urandom_range(0, 240000)) - 120000;
    ox = int'($urandom_range(0, 2 * reach)) - reach;
    oy = int'($urandom_range(0, 2 * reach)) - reach;
    case (kind)
      0: return make_seg($urandom, $urandom, $urandom, $urandom);
      1: ox = 0;
      2: oy = 0;
      3: oy = $urandom_range(0, 1) ? ox : -ox;
      4: begin
        sx &= ~255;
        sy &= ~255;
        ox &= ~255;
        oy &= ~255;
      end
      default: ;
    endcase
    return make_seg(sx, sy, sx + ox, sy + oy);
  endfunction

  // Slave side: offers the pending segments and predicts each one on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        trace_cells(segment_t'(s_axis_tdata));
        segs_taken <= segs_taken + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (seg_pending_q.size() != 0 &&
            !(sender_idles && $urandom_range(0, 99) < 63) &&
            !(both_idle && $urandom_range(0, 99) < 14)) begin
          s_axis_tdata  <= seg_pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          segs_sent     <= segs_sent + 1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // A single long hold-off of the receiver while segments keep coming, so that
  // the output register and then the input side back up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && segs_taken == num_directed + 20) begin
      hold_cnt  <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Master side ready.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      m_axis_tready <= 1'b0;
    end else if (recv_stalls && $urandom_range(0, 99) < 63) begin
      m_axis_tready <= 1'b0;
    end else if (both_idle && $urandom_range(0, 99) < 14) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compares each accepted cell with the oldest one still due.
  always @(posedge clk_i) begin
    cell_t due;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cell_due_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected cell x=%0d y=%0d last=%b truncated=%b", $realtime,
                 $signed(m_axis_tdata[CELL_W-1:0]), $signed(m_axis_tdata[2*CELL_W-1:CELL_W]),
                 m_axis_tlast, m_axis_tuser);
      end else begin
        due = cell_due_q.pop_front();
        if (m_axis_tdata[CELL_W-1:0] !== due.cell_x ||
            m_axis_tdata[2*CELL_W-1:CELL_W] !== due.cell_y ||
            m_axis_tlast !== due.last || m_axis_tuser !== due.truncated) begin
          fail_count++;
          $display("%0t: mismatch exp x=%0d y=%0d l=%b t=%b got x=%0d y=%0d l=%b t=%b",
                   $realtime, $signed(due.cell_x), $signed(due.cell_y), due.last, due.truncated,
                   $signed(m_axis_tdata[CELL_W-1:0]),
                   $signed(m_axis_tdata[2*CELL_W-1:CELL_W]), m_axis_tlast, m_axis_tuser);
        end
      end
    end
  end

  initial begin
    // Directed segments: single cells, both axis-aligned directions, ties,
    // the run length either side of the cap and the corners of the field.
    queue_seg(make_seg(0, 0, 0, 0));
    queue_seg(make_seg(-1, -1, -1, -1));
    queue_seg(make_seg(128, 64, 128, 5 * 256 + 3));
    queue_seg(make_seg(-300, 700, -300, -900));
    queue_seg(make_seg(10, 20, 2000, 20));
    queue_seg(make_seg(1000, -5, -1000, -5));
    queue_seg(make_seg(0, 0, 768, 768));
    queue_seg(make_seg(0, 0, -768, -512));
    queue_seg(make_seg(37, 201, 1500, -900));
    queue_seg(make_seg(0, 0, 63 * 256 + 10, 0));
    queue_seg(make_seg(0, 0, 64 * 256, 0));
    queue_seg(make_seg(0, 0, 0, -63 * 256 - 1));
    queue_seg(make_seg(-131072, -131072, 131071, 131071));
    queue_seg(make_seg(131071, 131071, -131072, -131072));
    queue_seg(make_seg(131071, -131072, -131072, 131071));
    queue_seg(make_seg(-10, -10, 10, 10));
    queue_seg(make_seg(5, 3, 300, 4000));
    queue_seg(make_seg(256, 256, 512, 1024));
    queue_seg(make_seg(-131072, 0, -131072, 255));
    queue_seg(make_seg(255, 255, 256, 256));
    queue_seg(make_seg(131071, 5, 131071 - 2560, 600));
    queue_seg(make_seg(-131072, 131071, -131072 + 2000, 131071 - 3000));
    num_directed = seg_pending_q.size();
    for (int i = 0; i < NUM_RANDOM; i++) begin
      queue_seg(random_seg());
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (seg_pending_q.size() != 0 || s_axis_tvalid || cell_due_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (fail_count == 0 && cell_due_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gsct_pkg.sv
rtl/grid_segment_cell_traversal.sv
tb/grid_segment_cell_traversal_tb.sv
